/* rtl/core/cnms_pkg.sv */
// Shared types, constants and the angle-to-sector function for the
// non-maximum suppression unit. No dependencies.
`timescale 1ns / 1ps

package cnms_pkg;

  // Sizing
  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned MAG_W     = 16;
  localparam int unsigned DIR_W     = 13;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned OCOL_W    = 10;
  localparam int unsigned CFG_WW    = 11;
  localparam int unsigned CFG_HW    = 16;
  localparam int unsigned CFG_DW    = 16;
  localparam int unsigned WEFF_W    = (COL_W + 1 > CFG_WW) ? COL_W + 1 : CFG_WW;

  // Stream packing
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 48;

  // Register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [CFG_WW-1:0] WIDTH_RST  = CFG_WW'(1024);
  localparam logic [CFG_HW-1:0] HEIGHT_RST = CFG_HW'(1024);

  // Sector boundaries in 1/16 degree
  localparam logic signed [DIR_W:0] ANG_22_5  = 14'sd360;
  localparam logic signed [DIR_W:0] ANG_67_5  = 14'sd1080;
  localparam logic signed [DIR_W:0] ANG_112_5 = 14'sd1800;
  localparam logic signed [DIR_W:0] ANG_157_5 = 14'sd2520;
  localparam logic signed [DIR_W:0] ANG_180   = 14'sd2880;

  typedef enum logic [1:0] {
    SEC_HORZ    = 2'd0,
    SEC_DIAG_UR = 2'd1,
    SEC_VERT    = 2'd2,
    SEC_DIAG_UL = 2'd3
  } sector_e;

  // One line buffer entry: sector of the row above plus two magnitude rows
  typedef struct packed {
    sector_e              sector;
    logic [MAG_W-1:0]     line1;
    logic [MAG_W-1:0]     line0;
  } line_word_t;

  localparam int unsigned LINE_WORD_W = $bits(line_word_t);

  // Position of one beat in the frame and what it emits
  typedef struct packed {
    logic [COL_W-1:0]  addr;
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
    logic              emit;
    logic              inner;
    logic              last;
  } pos_t;

  function automatic sector_e sector_of(input logic signed [DIR_W-1:0] dir);
    logic signed [DIR_W:0] a;
    sector_e               s;
    a = (dir < 0) ? (DIR_W+1)'(dir) + ANG_180 : (DIR_W+1)'(dir);
    if (a < 0 || a >= ANG_180) begin
      s = SEC_HORZ;
    end else if (a < ANG_22_5 || a >= ANG_157_5) begin
      s = SEC_HORZ;
    end else if (a < ANG_67_5) begin
      s = SEC_DIAG_UR;
    end else if (a < ANG_112_5) begin
      s = SEC_VERT;
    end else begin
      s = SEC_DIAG_UL;
    end
    return s;
  endfunction

endpackage

/* rtl/core/cnms_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module cnms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/cnms_cnt.sv */
// Configuration registers and row/column counters; places each input beat.
// Depends on cnms_pkg.
`timescale 1ns / 1ps

module cnms_cnt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [cnms_pkg::CFG_DW-1:0]   cfg_data_i,
  input  logic                          step_i,
  input  logic                          frame_start_i,
  output cnms_pkg::pos_t                pos_o
);
  import cnms_pkg::*;

  logic [CFG_WW-1:0] width_q;
  logic [CFG_HW-1:0] height_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;

  logic [WEFF_W-1:0] w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [COL_W-1:0]  c_start, c_cur;
  logic [ROW_W-1:0]  r_start, r_wrap, r_cur;
  logic [COL_W:0]    c_next;
  logic [ROW_W:0]    r_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WIDTH:  width_q  <= cfg_data_i[CFG_WW-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[CFG_HW-1:0];
        default:    ;
      endcase
    end
  end

  // Clamp the registers into their working range
  always_comb begin
    if (WEFF_W'(width_q) < WEFF_W'(3)) begin
      w_eff = WEFF_W'(3);
    end else if (WEFF_W'(width_q) > WEFF_W'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(width_q);
    end
    h_eff = (height_q < CFG_HW'(3)) ? ROW_W'(3) : height_q;
  end

  always_comb begin
    c_start = frame_start_i ? '0 : col_q;
    r_start = frame_start_i ? '0 : row_q;
    if (WEFF_W'(c_start) >= w_eff) begin
      c_cur  = '0;
      r_wrap = r_start + ROW_W'(1);
    end else begin
      c_cur  = c_start;
      r_wrap = r_start;
    end
    r_cur = (r_wrap >= h_eff) ? '0 : r_wrap;

    c_next = {1'b0, c_cur} + (COL_W+1)'(1);
    r_next = {1'b0, r_cur} + (ROW_W+1)'(1);
    if (WEFF_W'(c_next) >= w_eff) begin
      col_d = '0;
      row_d = (r_next >= {1'b0, h_eff}) ? '0 : r_next[ROW_W-1:0];
    end else begin
      col_d = c_next[COL_W-1:0];
      row_d = r_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (step_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Centre sits one row and one column behind the beat
  always_comb begin
    pos_o.addr  = c_cur;
    pos_o.row   = r_cur - ROW_W'(1);
    pos_o.col   = OCOL_W'(c_cur - COL_W'(1));
    pos_o.emit  = (r_cur != '0) && (c_cur != '0);
    pos_o.inner = (r_cur > ROW_W'(1)) && (c_cur > COL_W'(1));
    pos_o.last  = (r_cur == h_eff - ROW_W'(1)) && (WEFF_W'(c_cur) == w_eff - WEFF_W'(1));
  end

endmodule

/* rtl/core/cnms_win.sv */
// 3x3 magnitude window, centre sector and the suppression compare.
// Depends on cnms_pkg.
`timescale 1ns / 1ps

module cnms_win (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [cnms_pkg::MAG_W-1:0] mag_i,
  input  cnms_pkg::line_word_t      line_i,
  input  logic                      inner_i,
  output logic [cnms_pkg::MAG_W-1:0] suppressed_o
);
  import cnms_pkg::*;

  logic [2:0][2:0][MAG_W-1:0] win_q, win_d;
  sector_e                    sec_q;
  logic [MAG_W-1:0]           nb_fwd, nb_bwd, centre;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k][0] = win_q[k][1];
      win_d[k][1] = win_q[k][2];
    end
    win_d[0][2] = line_i.line1;
    win_d[1][2] = line_i.line0;
    win_d[2][2] = mag_i;
  end

  always_comb begin
    centre = win_d[1][1];
    unique case (sec_q)
      SEC_HORZ: begin
        nb_fwd = win_d[1][2];
        nb_bwd = win_d[1][0];
      end
      SEC_DIAG_UR: begin
        nb_fwd = win_d[2][0];
        nb_bwd = win_d[0][2];
      end
      SEC_VERT: begin
        nb_fwd = win_d[2][1];
        nb_bwd = win_d[0][1];
      end
      SEC_DIAG_UL: begin
        nb_fwd = win_d[0][0];
        nb_bwd = win_d[2][2];
      end
      default: begin
        nb_fwd = win_d[1][2];
        nb_bwd = win_d[1][0];
      end
    endcase
    suppressed_o = (inner_i && centre >= nb_fwd && centre >= nb_bwd) ? centre : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      sec_q <= SEC_HORZ;
    end else if (step_i) begin
      win_q <= win_d;
      sec_q <= line_i.sector;
    end
  end

endmodule

/* rtl/core/canny_non_max_suppression_unit.sv */
// Top level of the Canny non-maximum suppression unit: stream ports,
// line buffer RAM, input stage and result register.
// Depends on cnms_pkg, cnms_cnt, cnms_win and cnms_ram.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                Payload (lowest bit up)
// s_axis    in   tvalid/tready            tdata: magnitude, direction; tuser: frame_start
// m_axis    out  tvalid/tready            tdata: suppressed, out_row, out_col; tlast: frame_last
// cfg       in   cfg_we_i (no wait)       cfg_idx_i: 0 width, 1 height; cfg_data_i
//
// One pixel beat per cycle while m_axis does not stall. A beat is registered in
// the input stage, where the registered line buffer read lands, then its result
// goes to the output register, which drives m_axis_tvalid_o.
// Throughput is bound by the single-write line RAM: one write per pixel.
// Reset clears counters, window and valid flags; line buffer contents are
// not cleared and first become meaningful once a row has been written.
// A stall on m_axis holds the output register and back-pressures s_axis only
// when the input stage holds a beat that would emit a result.

module canny_non_max_suppression_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write port
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [cnms_pkg::CFG_DW-1:0]        cfg_data_i,
  // pixel input
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [cnms_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,  // magnitude[15:0], direction[28:16]
  input  logic                               s_axis_tuser_i,  // frame_start
  // result output
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [cnms_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,  // suppressed[15:0], out_row[31:16],
                                                              // out_col[41:32]
  output logic                               m_axis_tlast_o   // frame_last
);
  import cnms_pkg::*;

  // Input unpack
  logic [MAG_W-1:0]        in_mag;
  logic signed [DIR_W-1:0] in_dir;
  pos_t                    in_pos;
  logic                    in_acc;

  // Input stage
  logic             s1_valid_q;
  logic [MAG_W-1:0] s1_mag_q;
  sector_e          s1_sec_q;
  pos_t             s1_pos_q;
  logic             s1_adv;

  // Line buffer
  line_word_t                ram_rdata, line_rd, line_wr;
  logic [LINE_WORD_W-1:0]    ram_rdata_raw;
  logic                      fwd_q, fwd_d;
  line_word_t                fwd_data_q;

  // Output register
  logic                      out_valid_q;
  logic [OUT_TDATA_W-1:0]    out_data_q;
  logic                      out_last_q;
  logic                      out_free;
  logic [MAG_W-1:0]          suppressed;

  assign in_mag = s_axis_tdata_i[MAG_W-1:0];
  assign in_dir = s_axis_tdata_i[MAG_W +: DIR_W];

  // Handshake: the input stage drains whenever its beat needs no output slot
  // or the output register is free or being taken this cycle.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s1_adv          = s1_valid_q && (!s1_pos_q.emit || out_free);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  cnms_cnt u_cnt (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .step_i        (in_acc),
    .frame_start_i (s_axis_tuser_i),
    .pos_o         (in_pos)
  );

  // A beat whose column matches the one being written at the same edge
  // would read stale RAM data: take the written word instead.
  assign fwd_d = s1_adv && (s1_pos_q.addr == in_pos.addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= fwd_d;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mag_q   <= in_mag;
      s1_sec_q   <= sector_of(in_dir);
      s1_pos_q   <= in_pos;
      fwd_data_q <= line_wr;
    end
  end

  cnms_ram #(
    .WIDTH (LINE_WORD_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_pos_q.addr),
    .wdata_i (line_wr),
    .re_i    (in_acc),
    .raddr_i (in_pos.addr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = line_word_t'(ram_rdata_raw);
  assign line_rd   = fwd_q ? fwd_data_q : ram_rdata;

  // Shift the column down one line and store this beat's sector
  always_comb begin
    line_wr.sector = s1_sec_q;
    line_wr.line1  = line_rd.line0;
    line_wr.line0  = s1_mag_q;
  end

  cnms_win u_win (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_adv),
    .mag_i        (s1_mag_q),
    .line_i       (line_rd),
    .inner_i      (s1_pos_q.inner),
    .suppressed_o (suppressed)
  );

  // Output register: load on an emitting beat, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_pos_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_pos_q.emit) begin
      out_data_q <= OUT_TDATA_W'({s1_pos_q.col, s1_pos_q.row, suppressed});
      out_last_q <= s1_pos_q.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
